// ----- rtl/srit_pkg.sv -----
package srit_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int KEY_BYTES   = 30;
  localparam int KEY_W       = KEY_BYTES * 8;
  localparam int CNT_W       = 24;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ENTRY    = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    key_t key;
    cnt_t cnt;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic        action;
    logic [63:0] key_word_0;
    logic [63:0] key_word_1;
    logic [63:0] key_word_2;
    logic [47:0] key_word_3;
    logic [3:0]  male_head;
    logic [3:0]  male_young;
    logic [3:0]  male_rest;
    logic [3:0]  female_head;
    logic [3:0]  female_young;
    logic [3:0]  female_rest;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] out_key_0;
    logic [63:0] out_key_1;
    logic [63:0] out_key_2;
    logic [47:0] out_key_3;
    logic [5:0]  male_total;
    logic [5:0]  female_total;
    logic        last;
  } out_item_t;

endpackage

// ----- rtl/srit_ifs.sv -----
interface srit_in_if;
  logic               valid;
  logic               ready;
  srit_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srit_out_if;
  logic                valid;
  logic                ready;
  srit_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/srit_cell.sv -----
module srit_cell (
  input  logic                 clk,
  input  srit_pkg::cell_ctrl_t ctrl,
  input  srit_pkg::entry_t     new_entry,
  input  srit_pkg::entry_t     prev_entry,
  input  srit_pkg::entry_t     next_entry,
  input  srit_pkg::entry_t     head_entry,
  input  logic                 occupied,
  input  logic                 prev_less,
  input  logic                 is_tail,
  output logic                 less,
  output srit_pkg::entry_t     entry
);

  srit_pkg::entry_t entry_r;
  srit_pkg::entry_t entry_nxt;

  assign less  = occupied && (entry_r.key < new_entry.key);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert && !less) begin
      entry_nxt = prev_less ? new_entry : prev_entry;
    end else if (ctrl.rotate) begin
      entry_nxt = is_tail ? head_entry : next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- rtl/sorted_record_insert_table_core.sv -----
// A result is registered in out_data_r once its transaction is held and out_ch can take it.
// Throughput: one insert per cycle unless out_ch stalls; every stored entry compares against the
// new key in parallel. A read-out gives one entry per cycle, unless out_ch stalls, as the occupied
// cells rotate by one place; the next transaction is taken in the cycle the last entry is loaded.
// Reset: synchronous, active low; clears the fill count, the sequencer and the output valid.
// Cell contents are left as they are and are only read once written.
module sorted_record_insert_table_core (
  input  logic              clk,
  input  logic              rst_n,
  srit_in_if.sink           in_ch,
  srit_out_if.source        out_ch
);

  localparam int DEPTH = srit_pkg::TABLE_DEPTH;
  localparam int FW    = srit_pkg::FILL_W;
  localparam int IW    = srit_pkg::IDX_W;

  function automatic srit_pkg::key_t canon_key(srit_pkg::key_t k);
    logic [srit_pkg::KEY_BYTES-1:0] zb;
    logic                           ended;
    srit_pkg::key_t                 r;
    r = k;
    for (int b = 0; b < srit_pkg::KEY_BYTES; b++) begin
      zb[b] = (k[srit_pkg::KEY_W-1-8*b -: 8] == 8'h00);
    end
    for (int b = 0; b < srit_pkg::KEY_BYTES; b++) begin
      ended = 1'b0;
      for (int j = 0; j < b; j++) begin
        ended = ended | zb[j];
      end
      if (ended) begin
        r[srit_pkg::KEY_W-1-8*b -: 8] = 8'h00;
      end
    end
    return r;
  endfunction

  logic                busy_r;
  logic                hold_act_r;
  srit_pkg::entry_t    hold_entry_r;
  logic [FW-1:0]       fill_r;
  logic [IW-1:0]       rd_cnt_r;
  logic                out_valid_r;
  srit_pkg::out_item_t out_data_r;
  srit_pkg::out_item_t out_data_nxt;

  srit_pkg::entry_t    in_entry;
  srit_pkg::entry_t    cell_entry [DEPTH];
  logic [DEPTH-1:0]    cell_less;
  srit_pkg::cell_ctrl_t cell_ctrl;

  logic slot_free;
  logic full;
  logic empty;
  logic rd_last;
  logic op_done;
  logic in_fire;
  logic [5:0] head_male;
  logic [5:0] head_female;

  assign in_entry.key = canon_key({in_ch.data.key_word_0, in_ch.data.key_word_1,
                                   in_ch.data.key_word_2, in_ch.data.key_word_3});
  assign in_entry.cnt = {in_ch.data.female_rest, in_ch.data.female_young,
                         in_ch.data.female_head, in_ch.data.male_rest,
                         in_ch.data.male_young, in_ch.data.male_head};

  assign slot_free = !out_valid_r || out_ch.ready;
  assign full      = (fill_r == FW'(DEPTH));
  assign empty     = (fill_r == '0);
  assign rd_last   = (FW'(rd_cnt_r) == (fill_r - FW'(1)));
  assign op_done   = busy_r && slot_free &&
                     ((hold_act_r == srit_pkg::ACT_INSERT) || empty || rd_last);
  assign in_ch.ready = !busy_r || op_done;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign cell_ctrl.insert = busy_r && slot_free && (hold_act_r == srit_pkg::ACT_INSERT) && !full;
  assign cell_ctrl.rotate = busy_r && slot_free && (hold_act_r == srit_pkg::ACT_READ) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [FW-1:0] IDX = FW'(i);
    srit_pkg::entry_t prev_e;
    srit_pkg::entry_t next_e;
    logic             prev_l;

    if (i == 0) begin : g_first
      assign prev_e = hold_entry_r;
      assign prev_l = 1'b1;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_l = cell_less[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign next_e = cell_entry[0];
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
    end

    srit_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .new_entry  (hold_entry_r),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .head_entry (cell_entry[0]),
      .occupied   (IDX < fill_r),
      .prev_less  (prev_l),
      .is_tail    (IDX == (fill_r - FW'(1))),
      .less       (cell_less[i]),
      .entry      (cell_entry[i])
    );
  end

  assign head_male   = 6'(cell_entry[0].cnt[3:0]) + 6'(cell_entry[0].cnt[7:4]) +
                       6'(cell_entry[0].cnt[11:8]);
  assign head_female = 6'(cell_entry[0].cnt[15:12]) + 6'(cell_entry[0].cnt[19:16]) +
                       6'(cell_entry[0].cnt[23:20]);

  always_comb begin
    out_data_nxt      = '0;
    out_data_nxt.last = 1'b1;
    if (hold_act_r == srit_pkg::ACT_INSERT) begin
      out_data_nxt.status = full ? srit_pkg::ST_FULL : srit_pkg::ST_INSERTED;
    end else if (empty) begin
      out_data_nxt.status = srit_pkg::ST_EMPTY;
    end else begin
      out_data_nxt.status       = srit_pkg::ST_ENTRY;
      out_data_nxt.out_key_0    = cell_entry[0].key[239:176];
      out_data_nxt.out_key_1    = cell_entry[0].key[175:112];
      out_data_nxt.out_key_2    = cell_entry[0].key[111:48];
      out_data_nxt.out_key_3    = cell_entry[0].key[47:0];
      out_data_nxt.male_total   = head_male;
      out_data_nxt.female_total = head_female;
      out_data_nxt.last         = rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fill_r      <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (op_done) begin
        busy_r <= 1'b0;
      end
      if (cell_ctrl.insert) begin
        fill_r <= fill_r + FW'(1);
      end
      if (cell_ctrl.rotate) begin
        rd_cnt_r <= rd_last ? '0 : rd_cnt_r + IW'(1);
      end
      if (busy_r && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_act_r   <= in_ch.data.action;
      hold_entry_r <= in_entry;
    end
    if (busy_r && slot_free) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ----- rtl/srit_chk.sv -----
module srit_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input srit_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == srit_pkg::ST_INSERTED ||
                  out_data.status == srit_pkg::ST_FULL ||
                  out_data.status == srit_pkg::ST_EMPTY) |-> out_data.last)
    else $error("single result without last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != srit_pkg::ST_ENTRY |->
      out_data.male_total == 6'd0 && out_data.female_total == 6'd0 &&
      out_data.out_key_0 == 64'd0 && out_data.out_key_3 == 48'd0)
    else $error("status result carries entry data");

endmodule

bind sorted_record_insert_table_core srit_chk u_srit_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
